@@ design/lfu_pkg.sv @@
// Package: shared types and constants for the LFU replacement store.
`default_nettype none
package lfu_pkg;
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LIM_W    = 5;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] key;
    logic signed [31:0] write_value;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } out_t;

  // Write command broadcast to the row of cells.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             install;
    logic             set_value;
    logic [31:0]      key;
    logic [31:0]      value;
    logic [63:0]      stamp;
  } cell_wr_t;

  // Best-so-far candidate handed from cell to cell.
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic [31:0]      cnt;
    logic [63:0]      stamp;
  } scan_t;
endpackage
`default_nettype wire

@@ design/lfu_cell.sv @@
// One store entry: key, value, use count, stamp, and one victim-scan stage.
`default_nettype none
module lfu_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [lfu_pkg::IDX_W-1:0] cell_idx,
  input  wire logic                     occ,
  input  wire logic [31:0]              probe_key,
  output logic                          hit,
  output logic [31:0]                   value,
  input  wire lfu_pkg::cell_wr_t        wr,
  input  wire lfu_pkg::scan_t           scan_in,
  output lfu_pkg::scan_t                scan_out
);
  logic [31:0] key_r, value_r, cnt_r;
  logic [63:0] stamp_r;
  logic        sel, own_first;
  lfu_pkg::scan_t scan_r, scan_nxt;

  assign sel   = wr.en && (wr.idx == cell_idx);
  assign hit   = occ && (key_r == probe_key);
  assign value = value_r;

  always_ff @(posedge clk) begin
    if (sel) begin
      stamp_r <= wr.stamp;
      if (wr.install) begin
        key_r   <= wr.key;
        value_r <= wr.value;
        cnt_r   <= 32'd1;
      end else begin
        if (wr.set_value) value_r <= wr.value;
        if (cnt_r != 32'hFFFF_FFFF) cnt_r <= cnt_r + 32'd1;
      end
    end
  end

  // Keep the lower (count, stamp) pair.
  always_comb begin
    own_first = (cnt_r < scan_in.cnt) ||
                ((cnt_r == scan_in.cnt) && (stamp_r < scan_in.stamp));
    scan_nxt = scan_in;
    if (occ && (!scan_in.vld || own_first)) begin
      scan_nxt.vld   = 1'b1;
      scan_nxt.idx   = cell_idx;
      scan_nxt.cnt   = cnt_r;
      scan_nxt.stamp = stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign scan_out = scan_r;
endmodule
`default_nettype wire

@@ design/lfu_cache_replacement_top.sv @@
// Top level: LFU key-value store built from a row of entry cells.
//
// Input channel in_valid/in_stall/in_data carries a get or a put transaction.
// A get returns one transaction on out_valid/out_stall/out_data: hit and the
// stored value, or hit low and -1 on a miss. A put returns nothing.
// cfg_we/cfg_wdata write capacity_limit (reset value 16, clamped to the
// number of cells); write it only while the block is idle.
// Timing: a transaction is taken in the idle state, and the key is compared in all
// cells at once in the compare step that follows. Gets, updates and appends then
// finish there, and a get result shows on the cycle after that.
// A put of a new key into a full store walks the victim search along the
// chain of cells, one cell per cycle, then installs the key over the victim.
// The victim is the entry with the lowest use count, oldest stamp on a tie.
// One transaction is in work at a time; in_stall is high while it runs.
// The result register lets the next transaction be taken while a result
// waits; a get waiting on a stalled result register holds in the compare step.
// Reset (synchronous, rst_n low) empties the store, clears the stamp counter
// and the result valid flag, and restores capacity_limit to 16.
`default_nettype none
module lfu_cache_replacement_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire lfu_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lfu_pkg::out_t       out_data,
  input  wire logic           cfg_we,
  input  wire logic [lfu_pkg::LIM_W-1:0] cfg_wdata
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam int         SC_W    = lfu_pkg::CNT_W;

  logic [1:0]                 state_r, state_nxt;
  lfu_pkg::in_t               item_r;
  logic [lfu_pkg::LIM_W-1:0]  cap_r;
  logic [lfu_pkg::CNT_W-1:0]  held_r, held_nxt, lim;
  logic [63:0]                stamp_r, stamp_nxt;
  logic [SC_W-1:0]            scan_cnt_r, scan_cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  lfu_pkg::out_t              out_r, out_nxt;
  lfu_pkg::cell_wr_t          wr;

  logic [lfu_pkg::CAPACITY-1:0] hit_vec, occ_vec;
  logic [31:0]                  cell_val [lfu_pkg::CAPACITY];
  lfu_pkg::scan_t               scan_chain [lfu_pkg::CAPACITY+1];
  logic                         any_hit;
  logic [lfu_pkg::IDX_W-1:0]    hit_idx;
  logic [31:0]                  hit_val;

  assign scan_chain[0] = '0;

  for (genvar g = 0; g < lfu_pkg::CAPACITY; g++) begin : g_cell
    assign occ_vec[g] = (lfu_pkg::CNT_W'(g) < held_r);
    lfu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (lfu_pkg::IDX_W'(g)),
      .occ      (occ_vec[g]),
      .probe_key(item_r.key),
      .hit      (hit_vec[g]),
      .value    (cell_val[g]),
      .wr       (wr),
      .scan_in  (scan_chain[g]),
      .scan_out (scan_chain[g+1])
    );
  end

  // Keys are unique, so OR the matching entry's index and value.
  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    hit_val = '0;
    for (int i = 0; i < lfu_pkg::CAPACITY; i++) begin
      if (hit_vec[i]) begin
        any_hit = 1'b1;
        hit_idx = hit_idx | lfu_pkg::IDX_W'(i);
        hit_val = hit_val | cell_val[i];
      end
    end
  end

  always_comb begin
    if (32'(cap_r) > 32'(lfu_pkg::CAPACITY)) lim = lfu_pkg::CNT_W'(lfu_pkg::CAPACITY);
    else                                     lim = lfu_pkg::CNT_W'(cap_r);
  end

  assign stamp_nxt = stamp_r + 64'd1;

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    scan_cnt_nxt  = scan_cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr            = '0;
    wr.key        = item_r.key;
    wr.value      = item_r.write_value;
    wr.stamp      = stamp_nxt;
    wr.idx        = hit_idx;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (item_r.cmd == lfu_pkg::CMD_GET) begin
          if (!out_valid_r || !out_stall) begin
            out_valid_nxt      = 1'b1;
            out_nxt.hit        = any_hit;
            out_nxt.read_value = any_hit ? hit_val : 32'hFFFF_FFFF;
            wr.en              = any_hit;
            state_nxt          = ST_IDLE;
          end
        end else if (lim == '0) begin
          state_nxt = ST_IDLE;
        end else if (any_hit) begin
          wr.en        = 1'b1;
          wr.set_value = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (held_r < lim) begin
          wr.en      = 1'b1;
          wr.install = 1'b1;
          wr.idx     = lfu_pkg::IDX_W'(held_r);
          held_nxt   = held_r + 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          scan_cnt_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Let the candidate travel the whole chain, then replace the victim.
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == SC_W'(lfu_pkg::CAPACITY - 1)) begin
          wr.en      = 1'b1;
          wr.install = 1'b1;
          wr.idx     = scan_chain[lfu_pkg::CAPACITY].idx;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      stamp_r     <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= lfu_pkg::LIM_W'(16);
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr.en) stamp_r <= stamp_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (state_r == ST_IDLE && in_valid) item_r <= in_data;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= lfu_pkg::CNT_W'(lfu_pkg::CAPACITY))
    else $error("entry count beyond capacity");
  a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("key held in more than one entry");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOOK))
    else $error("result raised outside compare step");
  a_scan_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_cnt_r == SC_W'(lfu_pkg::CAPACITY - 1))
      |-> scan_chain[lfu_pkg::CAPACITY].vld)
    else $error("victim search found no entry");
`endif
endmodule
`default_nettype wire
